/* hdl/lfb_pkg.sv */
// Package for the Lee filter block: payload structs, register indexes,
// reset values and the sequencer state type. No dependencies.
package lfb_pkg;

    localparam int DEF_MAX_RADIUS = 4;
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT     = 1024;

    localparam int PIX_W    = 8;
    localparam int CFG_W_W  = 11;
    localparam int CFG_H_W  = 11;
    localparam int CFG_R_W  = 3;
    localparam int CFG_NV_W = 16;
    localparam int CFG_IDX_W = 4;
    localparam int CFG_DATA_W = 16;
    localparam int POS_W    = 21;
    localparam int QUO_W    = 9;
    localparam int PIX_MAX  = 255;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH    = 4'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT   = 4'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_RADIUS  = 4'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE_VARIANCE = 4'd3;

    localparam logic [CFG_W_W-1:0]  RST_IMAGE_WIDTH    = 11'd600;
    localparam logic [CFG_H_W-1:0]  RST_IMAGE_HEIGHT   = 11'd480;
    localparam logic [CFG_R_W-1:0]  RST_WINDOW_RADIUS  = 3'd4;
    localparam logic [CFG_NV_W-1:0] RST_NOISE_VARIANCE = 16'd105;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    typedef struct packed {
        logic             action;
        logic [PIX_W-1:0] blue_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] red_in;
    } t_pix_in;

    typedef struct packed {
        logic [PIX_W-1:0] blue_out;
        logic [PIX_W-1:0] green_out;
        logic [PIX_W-1:0] red_out;
        logic             frame_end;
    } t_pix_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_DRAIN,
        ST_MUL1,
        ST_MUL2,
        ST_MUL3,
        ST_SUM,
        ST_DIV,
        ST_DONE
    } t_state;

endpackage

/* hdl/lee_filter_bgr.sv */
// Lee filter on a raster stream of BGR pixels, top level.
// Uses lfb_pkg and lfb_ram (the row store).
//
// Usage: pixels enter on the input channel (i_in_valid / o_in_ready) in
// raster order, one request per pixel; action = flush carries no pixel and
// drains the last results of a frame once the frame is complete. Results
// leave on the output channel (o_out_valid / i_out_ready), each result for
// the pixel r rows plus r pixels back, with frame_end on the last pixel.
// Registers are written on the configuration channel (i_cfg_valid /
// o_cfg_ready), index 0..3; any listed write restarts the frame.
// One item is handled at a time. A border pixel reads only its own
// sample and skips the multiply stages and the divider; an interior pixel
// runs the window sweep through the single read port of the row store,
// followed by the multiply stages and the nine-step restoring divider.
// The output register holds a result while the receiver stalls; the next
// request is still taken, and the block waits only when a new result is
// ready before the previous one was taken.
// Reset (synchronous, active low) restores register defaults and empties
// the frame; the row store needs no clearing since only pixels written in
// the current frame are read.
module lee_filter_bgr #(
    parameter int MAX_RADIUS = lfb_pkg::DEF_MAX_RADIUS,
    parameter int MAX_WIDTH  = lfb_pkg::DEF_MAX_WIDTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  lfb_pkg::t_pix_in                    i_in,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output lfb_pkg::t_pix_out                   o_out,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [lfb_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [lfb_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import lfb_pkg::*;

    localparam int NROWS  = 2 * MAX_RADIUS + 1;
    localparam int DEPTH  = NROWS * MAX_WIDTH;
    localparam int A_W    = $clog2(DEPTH);
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int SLOT_W = $clog2(NROWS);
    localparam int NMAX   = NROWS * NROWS;
    localparam int N_W    = $clog2(NMAX + 1);
    localparam int S_W    = $clog2(NMAX * 255 + 1);
    localparam int Q_W    = $clog2(NMAX * 65025 + 1);
    localparam int D_W    = N_W + Q_W;
    localparam int NN_W   = CFG_NV_W + N_W;
    localparam int T4_W   = NN_W + S_W;
    localparam int T5_W   = NN_W + N_W;
    localparam int T6_W   = D_W + PIX_W;
    localparam int DEN_W  = ((D_W > T5_W) ? D_W : T5_W) + 1;
    localparam int NUM_W  = ((T4_W > T6_W) ? T4_W : T6_W) + 1;
    localparam int CMP_W  = (NUM_W > DEN_W + QUO_W - 1) ? NUM_W : DEN_W + QUO_W - 1;
    localparam int STEP_W = $clog2(QUO_W);

    // configuration
    logic [CFG_W_W-1:0]  r_cfg_w;
    logic [CFG_H_W-1:0]  r_cfg_h;
    logic [CFG_R_W-1:0]  r_cfg_r;
    logic [CFG_NV_W-1:0] r_cfg_nv;

    // frame positions
    logic [POS_W-1:0]   r_ip, r_op;
    logic [COL_W-1:0]   r_in_col, r_out_col;
    logic [SLOT_W-1:0]  r_in_slot, r_out_slot;
    logic [CFG_H_W-1:0] r_out_row;

    t_state r_state, n_state;

    // window sweep
    logic [SLOT_W-1:0] r_rd_slot, r_dy, r_dx;
    logic [COL_W-1:0]  r_rd_col;
    logic              r_rd_valid, r_rd_center, r_interior;

    // per-channel datapath
    logic [S_W-1:0]   r_s   [3];
    logic [Q_W-1:0]   r_q   [3];
    logic [PIX_W-1:0] r_pix [3];
    logic [D_W-1:0]   r_t1  [3];
    logic [D_W-1:0]   r_t2  [3];
    logic [D_W-1:0]   r_d   [3];
    logic [T4_W-1:0]  r_t4  [3];
    logic [T6_W-1:0]  r_t6  [3];
    logic [DEN_W-1:0] r_den [3];
    logic [CMP_W-1:0] r_rem [3];
    logic [CMP_W-1:0] r_dsh [3];
    logic [QUO_W-1:0] r_quo [3];
    logic [NN_W-1:0]  r_nn;
    logic [T5_W-1:0]  r_t5;
    logic [STEP_W-1:0] r_step;

    t_pix_out r_out;
    logic     r_out_valid;

    // effective settings
    logic [CFG_W_W-1:0] eff_w;
    logic [CFG_H_W-1:0] eff_h;
    logic [CFG_R_W-1:0] eff_r;
    logic [CFG_NV_W-1:0] eff_nv;
    logic [POS_W-1:0]   total, lag;
    logic [SLOT_W-1:0]  win_last, win_start_slot;
    logic [N_W-1:0]     n_cnt;
    logic               interior_now;

    // ram ports
    logic              ram_we;
    logic [A_W-1:0]    ram_waddr, ram_raddr;
    logic [3*PIX_W-1:0] ram_wdata, ram_rdata;

    // request decode
    logic              in_fire, cfg_fire, cfg_listed;
    logic              new_frame, start, rd_last, out_free, frame_end;
    logic [POS_W-1:0]  base_ip, base_op, op_inc;
    logic [COL_W-1:0]  base_col;
    logic [SLOT_W-1:0] base_slot;
    logic [PIX_W-1:0]  lane_v [3];

    always_comb begin
        eff_w = (r_cfg_w == '0) ? CFG_W_W'(1)
              : ((32'(r_cfg_w) > MAX_WIDTH) ? CFG_W_W'(MAX_WIDTH) : r_cfg_w);
        eff_h = (r_cfg_h == '0) ? CFG_H_W'(1)
              : ((32'(r_cfg_h) > MAX_HEIGHT) ? CFG_H_W'(MAX_HEIGHT) : r_cfg_h);
        eff_r = (r_cfg_r == '0) ? CFG_R_W'(1)
              : ((32'(r_cfg_r) > MAX_RADIUS) ? CFG_R_W'(MAX_RADIUS) : r_cfg_r);
        eff_nv = (r_cfg_nv == '0) ? CFG_NV_W'(1) : r_cfg_nv;
        total = POS_W'(eff_w) * POS_W'(eff_h);
        lag   = POS_W'(eff_r) * POS_W'(eff_w) + POS_W'(eff_r);
        win_last = SLOT_W'({eff_r, 1'b0});
        n_cnt = N_W'(win_last + 1'b1) * N_W'(win_last + 1'b1);
        win_start_slot = (32'(r_out_slot) >= 32'(eff_r))
                       ? SLOT_W'(r_out_slot - SLOT_W'(eff_r))
                       : SLOT_W'(32'(r_out_slot) + NROWS - 32'(eff_r));
        interior_now = (32'(eff_w) >= 32'(win_last) + 1)
                    && (32'(eff_h) >= 32'(win_last) + 1)
                    && (32'(r_out_col) >= 32'(eff_r))
                    && (32'(r_out_col) + 32'(eff_r) < 32'(eff_w))
                    && (32'(r_out_row) >= 32'(eff_r))
                    && (32'(r_out_row) + 32'(eff_r) < 32'(eff_h));
    end

    always_comb begin
        cfg_fire   = i_cfg_valid && o_cfg_ready;
        cfg_listed = (i_cfg_index == CFG_IMAGE_WIDTH) || (i_cfg_index == CFG_IMAGE_HEIGHT)
                  || (i_cfg_index == CFG_WINDOW_RADIUS) || (i_cfg_index == CFG_NOISE_VARIANCE);
        in_fire   = i_in_valid && o_in_ready;
        new_frame = (r_ip >= total);
        base_ip   = new_frame ? '0 : r_ip;
        base_op   = new_frame ? '0 : r_op;
        base_col  = new_frame ? '0 : r_in_col;
        base_slot = new_frame ? '0 : r_in_slot;
        if (i_in.action == ACT_FLUSH) begin
            start = in_fire && new_frame && (r_op < total);
        end else begin
            start = in_fire && (base_ip + 1'b1 > lag) && (base_op < total);
        end
        rd_last  = !r_interior || ((r_dy == win_last) && (r_dx == win_last));
        out_free = !r_out_valid || i_out_ready;
        op_inc   = r_op + 1'b1;
        frame_end = (op_inc >= total);
        lane_v[0] = ram_rdata[PIX_W-1:0];
        lane_v[1] = ram_rdata[2*PIX_W-1:PIX_W];
        lane_v[2] = ram_rdata[3*PIX_W-1:2*PIX_W];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:  if (start) n_state = ST_READ;
            ST_READ:  if (rd_last) n_state = ST_DRAIN;
            ST_DRAIN: n_state = r_interior ? ST_MUL1 : ST_DONE;
            ST_MUL1:  n_state = ST_MUL2;
            ST_MUL2:  n_state = ST_MUL3;
            ST_MUL3:  n_state = ST_SUM;
            ST_SUM:   n_state = ST_DIV;
            ST_DIV:   if (32'(r_step) == QUO_W - 1) n_state = ST_DONE;
            ST_DONE:  if (out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // outputs and memory ports
    always_comb begin
        o_in_ready  = (r_state == ST_IDLE);
        o_cfg_ready = 1'b1;
        ram_we      = in_fire && (i_in.action == ACT_PIXEL);
        ram_waddr   = A_W'(base_slot) * A_W'(MAX_WIDTH) + A_W'(base_col);
        ram_wdata   = {i_in.red_in, i_in.green_in, i_in.blue_in};
        ram_raddr   = A_W'(r_rd_slot) * A_W'(MAX_WIDTH) + A_W'(r_rd_col);
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    lfb_ram #(
        .WIDTH(3 * PIX_W),
        .DEPTH(DEPTH)
    ) u_row_store (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cfg_w     <= RST_IMAGE_WIDTH;
            r_cfg_h     <= RST_IMAGE_HEIGHT;
            r_cfg_r     <= RST_WINDOW_RADIUS;
            r_cfg_nv    <= RST_NOISE_VARIANCE;
            r_ip        <= '0;
            r_op        <= '0;
            r_in_col    <= '0;
            r_in_slot   <= '0;
            r_out_col   <= '0;
            r_out_row   <= '0;
            r_out_slot  <= '0;
            r_out_valid <= 1'b0;
            r_rd_valid  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_valid <= (r_state == ST_READ);
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_fire && cfg_listed) begin
                unique case (i_cfg_index)
                    CFG_IMAGE_WIDTH:   r_cfg_w  <= i_cfg_data[CFG_W_W-1:0];
                    CFG_IMAGE_HEIGHT:  r_cfg_h  <= i_cfg_data[CFG_H_W-1:0];
                    CFG_WINDOW_RADIUS: r_cfg_r  <= i_cfg_data[CFG_R_W-1:0];
                    default:           r_cfg_nv <= i_cfg_data[CFG_NV_W-1:0];
                endcase
                r_ip       <= '0;
                r_op       <= '0;
                r_in_col   <= '0;
                r_in_slot  <= '0;
                r_out_col  <= '0;
                r_out_row  <= '0;
                r_out_slot <= '0;
            end else if (in_fire && (i_in.action == ACT_PIXEL)) begin
                r_ip <= base_ip + 1'b1;
                if (new_frame) begin
                    r_op       <= '0;
                    r_out_col  <= '0;
                    r_out_row  <= '0;
                    r_out_slot <= '0;
                end
                if (32'(base_col) + 1 == 32'(eff_w)) begin
                    r_in_col  <= '0;
                    r_in_slot <= (32'(base_slot) == NROWS - 1) ? '0 : base_slot + 1'b1;
                end else begin
                    r_in_col  <= base_col + 1'b1;
                    r_in_slot <= base_slot;
                end
            end else if ((r_state == ST_DONE) && out_free) begin
                r_out_valid <= 1'b1;
                if (frame_end) begin
                    r_ip       <= '0;
                    r_op       <= '0;
                    r_in_col   <= '0;
                    r_in_slot  <= '0;
                    r_out_col  <= '0;
                    r_out_row  <= '0;
                    r_out_slot <= '0;
                end else begin
                    r_op <= op_inc;
                    if (32'(r_out_col) + 1 == 32'(eff_w)) begin
                        r_out_col  <= '0;
                        r_out_row  <= r_out_row + 1'b1;
                        r_out_slot <= (32'(r_out_slot) == NROWS - 1) ? '0 : r_out_slot + 1'b1;
                    end else begin
                        r_out_col <= r_out_col + 1'b1;
                    end
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_interior <= interior_now;
                r_dy       <= '0;
                r_dx       <= '0;
                r_step     <= '0;
                if (interior_now) begin
                    r_rd_slot <= win_start_slot;
                    r_rd_col  <= r_out_col - COL_W'(eff_r);
                end else begin
                    r_rd_slot <= r_out_slot;
                    r_rd_col  <= r_out_col;
                end
                for (int ln = 0; ln < 3; ln++) begin
                    r_s[ln] <= '0;
                    r_q[ln] <= '0;
                end
            end
            ST_READ: begin
                r_rd_center <= !r_interior
                            || ((32'(r_dy) == 32'(eff_r)) && (32'(r_dx) == 32'(eff_r)));
                if (r_dx == win_last) begin
                    r_dx      <= '0;
                    r_dy      <= r_dy + 1'b1;
                    r_rd_col  <= r_out_col - COL_W'(eff_r);
                    r_rd_slot <= (32'(r_rd_slot) == NROWS - 1) ? '0 : r_rd_slot + 1'b1;
                end else begin
                    r_dx     <= r_dx + 1'b1;
                    r_rd_col <= r_rd_col + 1'b1;
                end
            end
            ST_MUL1: begin
                r_nn <= NN_W'(eff_nv) * NN_W'(n_cnt);
                for (int ln = 0; ln < 3; ln++) begin
                    r_t1[ln] <= D_W'(n_cnt) * D_W'(r_q[ln]);
                    r_t2[ln] <= D_W'(r_s[ln]) * D_W'(r_s[ln]);
                end
            end
            ST_MUL2: begin
                r_t5 <= T5_W'(r_nn) * T5_W'(n_cnt);
                for (int ln = 0; ln < 3; ln++) begin
                    r_d[ln]  <= r_t1[ln] - r_t2[ln];
                    r_t4[ln] <= T4_W'(r_nn) * T4_W'(r_s[ln]);
                end
            end
            ST_MUL3: begin
                for (int ln = 0; ln < 3; ln++) begin
                    r_t6[ln]  <= T6_W'(r_d[ln]) * T6_W'(r_pix[ln]);
                    r_den[ln] <= DEN_W'(r_d[ln]) + DEN_W'(r_t5);
                end
            end
            ST_SUM: begin
                for (int ln = 0; ln < 3; ln++) begin
                    r_rem[ln] <= CMP_W'(r_t4[ln]) + CMP_W'(r_t6[ln]);
                    r_dsh[ln] <= CMP_W'(r_den[ln]) << (QUO_W - 1);
                    r_quo[ln] <= '0;
                end
            end
            ST_DIV: begin
                r_step <= r_step + 1'b1;
                for (int ln = 0; ln < 3; ln++) begin
                    if (r_rem[ln] >= r_dsh[ln]) begin
                        r_rem[ln] <= r_rem[ln] - r_dsh[ln];
                        r_quo[ln] <= {r_quo[ln][QUO_W-2:0], 1'b1};
                    end else begin
                        r_quo[ln] <= {r_quo[ln][QUO_W-2:0], 1'b0};
                    end
                    r_dsh[ln] <= r_dsh[ln] >> 1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    if (r_interior) begin
                        r_out.blue_out  <= r_quo[0][QUO_W-1] ? PIX_W'(PIX_MAX) : r_quo[0][PIX_W-1:0];
                        r_out.green_out <= r_quo[1][QUO_W-1] ? PIX_W'(PIX_MAX) : r_quo[1][PIX_W-1:0];
                        r_out.red_out   <= r_quo[2][QUO_W-1] ? PIX_W'(PIX_MAX) : r_quo[2][PIX_W-1:0];
                    end else begin
                        r_out.blue_out  <= r_pix[0];
                        r_out.green_out <= r_pix[1];
                        r_out.red_out   <= r_pix[2];
                    end
                    r_out.frame_end <= frame_end;
                end
            end
            default: begin
            end
        endcase

        // Read data arrives in the cycle after its address, so it is summed here
        // in both the sweep and the drain cycle.
        if (r_rd_valid) begin
            for (int ln = 0; ln < 3; ln++) begin
                r_s[ln] <= r_s[ln] + S_W'(lane_v[ln]);
                r_q[ln] <= r_q[ln] + Q_W'(lane_v[ln]) * Q_W'(lane_v[ln]);
                if (r_rd_center) begin
                    r_pix[ln] <= lane_v[ln];
                end
            end
        end
    end

    // The output count can never pass the input count within a frame.
    a_op_le_ip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_op <= r_ip)
        else $error("output position ahead of input position");

    // The divisor always carries the noise term, so it is never zero.
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_dsh[0] != '0 && r_dsh[1] != '0 && r_dsh[2] != '0))
        else $error("zero divisor in divider");

    // The filtered value is a weighted mean of samples, so it fits a pixel.
    a_quo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && r_interior) |->
            (r_quo[0][QUO_W-1] == 1'b0 && r_quo[1][QUO_W-1] == 1'b0
             && r_quo[2][QUO_W-1] == 1'b0))
        else $error("quotient exceeds pixel range");

    // A sweep always leaves through the drain cycle.
    a_read_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ && rd_last) |=> (r_state == ST_DRAIN && r_rd_valid))
        else $error("window sweep did not drain");

endmodule

/* hdl/lfb_ram.sv */
// Generic simple dual-port RAM: one write port, one read port with
// registered read data. No package dependencies.
module lfb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 9216
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
